@@ hw/rtl/bla_pkg.sv @@
// ----------------------------------------------------------------------------
// Block list allocator package
// Shared types, codes and sizes of the block list allocator.
// ----------------------------------------------------------------------------
package bla_pkg;

  localparam int unsigned MaxEntries = 32;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = 6;
  localparam logic [15:0] PoolReset  = 16'd100;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_RECLAIM = 3'd1,
    OP_FREE    = 3'd2,
    OP_MERGE   = 3'd3,
    OP_DELETE  = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_READ    = 3'd6,
    OP_NONE    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOSPACE   = 3'd1,
    ST_ALLOCATED = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_MERGE,
    S_READ,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] size;
    logic [15:0] block_id;
    logic [4:0]  position;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_id;
    logic [15:0] result_size;
    logic        is_free;
    logic [15:0] free_space;
    logic [5:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] size;
    logic        free;
  } entry_t;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    entry_t          wr_data;
  } mem_req_t;

endpackage

@@ hw/rtl/bla_table.sv @@
// ----------------------------------------------------------------------------
// Block list allocator table
// Entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bla_table (
  input  logic              clk_i,
  input  bla_pkg::mem_req_t req_i,
  output bla_pkg::entry_t   rd_data_o
);
  import bla_pkg::*;

  entry_t mem_q [MaxEntries];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end

endmodule

@@ hw/rtl/bla_seq.sv @@
// ----------------------------------------------------------------------------
// Block list allocator sequencer
// Walks the table one entry per step for lookups, shifts and merges.
// ----------------------------------------------------------------------------
module bla_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bla_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bla_pkg::out_t     out_data_o,
  input  logic [15:0]       capacity_i,
  output bla_pkg::mem_req_t req_o,
  input  bla_pkg::entry_t   rd_data_i,
  output logic [5:0]        count_o
);
  import bla_pkg::*;

  state_e state_q, state_d;
  in_t    item_q, item_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     pool_q, pool_d, next_id_q, next_id_d;
  // Walk pointer: ptr_q - 1 is the address read last cycle; dst_q is merge write side.
  logic [CntW-1:0] ptr_q, ptr_d, dst_q, dst_d;
  logic            pend_q, pend_d;  // read data valid (for ptr_q - 1 in walks and shifts)
  entry_t          hold_q, hold_d;  // merge accumulator
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            ovalid_q, ovalid_d;

  logic [CntW-1:0] cur;
  logic            id_hit;
  logic [16:0]     msum;

  assign cur    = ptr_q - 1'b1;
  assign id_hit = rd_data_i.id == item_q.block_id;
  assign msum   = {1'b0, hold_q.size} + {1'b0, rd_data_i.size};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        unique case (op_e'(in_data_i.op))
          OP_ALLOC: state_d = ({1'b0, in_data_i.size} > {1'b0, pool_q} ||
                               count_q >= CntW'(MaxEntries)) ? S_DONE : S_SHIFT;
          OP_RECLAIM, OP_FREE, OP_DELETE:
            state_d = (count_q == '0) ? S_DONE : S_SCAN;
          OP_MERGE: state_d = (count_q == '0) ? S_DONE : S_MERGE;
          OP_READ: state_d = ({1'b0, in_data_i.position} >= count_q) ? S_DONE : S_READ;
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: if (pend_q) begin
        if (op_e'(item_q.op) == OP_DELETE) begin
          if (dst_q != '0) state_d = (ptr_q >= count_q) ? S_DONE : S_SCAN;
          else if (id_hit) state_d = (ptr_q >= count_q) ? S_DONE : S_SCAN;
          else if (ptr_q >= count_q) state_d = S_DONE;
        end else if (id_hit && (op_e'(item_q.op) == OP_RECLAIM || !rd_data_i.free)) begin
          state_d = S_DONE;
        end else if (ptr_q >= count_q) begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: if (ptr_q == '0) state_d = S_DONE;
      S_MERGE: if (!pend_q) state_d = S_DONE;
      S_READ:  if (pend_q) state_d = S_DONE;
      S_DONE:  if (!ovalid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    item_d = item_q; count_d = count_q; pool_d = pool_q; next_id_d = next_id_q;
    ptr_d = ptr_q; dst_d = dst_q; pend_d = 1'b0; hold_d = hold_q;
    res_d = res_q; out_d = out_q; ovalid_d = ovalid_q;
    req_o = '0;
    in_ready_o = (state_q == S_IDLE);
    if (out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        item_d = in_data_i;
        res_d = '0;
        res_d.status = ST_OK;
        ptr_d = '0; dst_d = '0;
        unique case (op_e'(in_data_i.op))
          OP_ALLOC: begin
            if ({1'b0, in_data_i.size} > {1'b0, pool_q}) res_d.status = ST_NOSPACE;
            else if (count_q >= CntW'(MaxEntries)) res_d.status = ST_FULL;
            else ptr_d = count_q;
          end
          OP_RECLAIM: res_d.status = (count_q == '0) ? ST_EMPTY : ST_NOTFOUND;
          OP_FREE, OP_DELETE: res_d.status = ST_NOTFOUND;
          OP_CLEAR: begin
            count_d = '0;
            pool_d = capacity_i;
          end
          OP_READ: begin
            if ({1'b0, in_data_i.position} >= count_q) res_d.status = ST_NOTFOUND;
            else begin
              req_o.rd_en = 1'b1;
              req_o.rd_addr = in_data_i.position;
            end
          end
          default: ;
        endcase
        if (op_e'(in_data_i.op) == OP_RECLAIM || op_e'(in_data_i.op) == OP_FREE ||
            op_e'(in_data_i.op) == OP_DELETE || op_e'(in_data_i.op) == OP_MERGE) begin
          if (count_q != '0) begin
            req_o.rd_en = 1'b1; req_o.rd_addr = '0; ptr_d = CntW'(1); pend_d = 1'b1;
          end
        end
        pend_d = pend_d | (op_e'(in_data_i.op) == OP_READ);
      end
      S_SCAN: if (pend_q) begin
        if (ptr_q < count_q) begin
          req_o.rd_en = 1'b1; req_o.rd_addr = IdxW'(ptr_q); ptr_d = ptr_q + 1'b1;
          pend_d = 1'b1;
        end
        unique case (op_e'(item_q.op))
          OP_DELETE: begin
            if (dst_q != '0) begin
              // Shift down the entry after the removed one.
              req_o.wr_en = 1'b1; req_o.wr_addr = IdxW'(cur - 1'b1);
              req_o.wr_data = rd_data_i;
            end else if (id_hit) begin
              dst_d = CntW'(1);
              res_d.status = ST_OK;
              pool_d = ({1'b0, pool_q} + {1'b0, rd_data_i.size} > 17'hFFFF) ?
                       16'hFFFF : pool_q + rd_data_i.size;
            end
            if ((dst_q != '0 || id_hit) && ptr_q >= count_q) count_d = count_q - 1'b1;
          end
          default: begin
            if (id_hit && (op_e'(item_q.op) == OP_RECLAIM || !rd_data_i.free)) begin
              pend_d = 1'b0; req_o.rd_en = 1'b0;
              if (op_e'(item_q.op) == OP_RECLAIM && !rd_data_i.free) begin
                res_d.status = ST_ALLOCATED;
              end else begin
                res_d.status = ST_OK;
                req_o.wr_en = 1'b1; req_o.wr_addr = IdxW'(cur);
                req_o.wr_data = rd_data_i;
                req_o.wr_data.free = (op_e'(item_q.op) == OP_FREE);
              end
            end
          end
        endcase
      end
      S_SHIFT: begin
        // Move entries up by one from the tail, one per two-phase step.
        if (ptr_q == '0) begin
          req_o.wr_en = 1'b1; req_o.wr_addr = '0;
          req_o.wr_data = '{id: next_id_q, size: item_q.size, free: 1'b0};
          count_d = count_q + 1'b1;
          pool_d = pool_q - item_q.size;
          res_d.result_id = next_id_q;
          next_id_d = next_id_q + 1'b1;
        end else if (!pend_q) begin
          req_o.rd_en = 1'b1; req_o.rd_addr = IdxW'(ptr_q - 1'b1); pend_d = 1'b1;
        end else begin
          req_o.wr_en = 1'b1; req_o.wr_addr = IdxW'(ptr_q);
          req_o.wr_data = rd_data_i;
          ptr_d = ptr_q - 1'b1;
        end
      end
      S_MERGE: if (pend_q) begin
        if (ptr_q < count_q) begin
          req_o.rd_en = 1'b1; req_o.rd_addr = IdxW'(ptr_q); ptr_d = ptr_q + 1'b1;
          pend_d = 1'b1;
        end
        if (dst_q != '0 && rd_data_i.free && hold_q.free) begin
          hold_d.size = msum[16] ? 16'hFFFF : msum[15:0];
        end else begin
          if (dst_q != '0) begin
            req_o.wr_en = 1'b1; req_o.wr_addr = IdxW'(dst_q - 1'b1);
            req_o.wr_data = hold_q;
          end
          hold_d = rd_data_i;
          dst_d = dst_q + 1'b1;
        end
      end else begin
        // All entries seen: write back the last open entry.
        req_o.wr_en = 1'b1; req_o.wr_addr = IdxW'(dst_q - 1'b1);
        req_o.wr_data = hold_q;
        count_d = dst_q;
      end
      S_READ: if (pend_q) begin
        res_d.result_id = rd_data_i.id;
        res_d.result_size = rd_data_i.size;
        res_d.is_free = rd_data_i.free;
      end
      S_DONE: if (!ovalid_q || out_ready_i) begin
        out_d = res_q;
        out_d.free_space = pool_q;
        out_d.entry_count = count_q;
        ovalid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // State and registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; pool_q <= PoolReset; next_id_q <= '0;
      ptr_q <= '0; dst_q <= '0; pend_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; pool_q <= pool_d;
      next_id_q <= next_id_d; ptr_q <= ptr_d; dst_q <= dst_d;
      pend_q <= pend_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; hold_q <= hold_d; res_q <= res_d; out_q <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;
  assign count_o     = count_q;

endmodule

@@ hw/rtl/block_list_allocator.sv @@
// ----------------------------------------------------------------------------
// Block list allocator
// Ordered block table with allocate, reclaim, free, merge, delete and read.
// ----------------------------------------------------------------------------
// One operation is taken at a time, and the input is ready only while the
// sequencer is idle. Lookups and deletes walk the table one entry per cycle
// through an entry memory with one write port and one registered read port;
// merge walks it the same way, and allocate shifts the table up from the tail
// with a read and then a write for each entry. Read does one table lookup, and
// clear, the unused code and any operation refused up front go straight to the
// result. The result sits in an output register: the next beat can be taken
// while it waits, but that beat does not finish until the register drains.
module block_list_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bla_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bla_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);
  import bla_pkg::*;

  logic [15:0] capacity_q;
  mem_req_t    req;
  entry_t      rd_data;
  logic [5:0]  count;

  // Capacity register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= PoolReset;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  bla_seq u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .capacity_i(capacity_q), .req_o(req), .rd_data_i(rd_data), .count_o(count)
  );

  bla_table u_table (.clk_i, .req_i(req), .rd_data_o(rd_data));

  // Entry count never exceeds the table depth.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= 6'(MaxEntries)) else $error("entry count above depth");

  // No write past the current count plus one slot.
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.wr_en |-> {1'b0, req.wr_addr} <= count) else $error("write beyond table");

  // A waiting result beat holds its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result beat changed while waiting");

endmodule
